>>> hw/rtl/cspe_pkg.sv
// ----------------------------------------------------------------------------
// Cubic spline point evaluator package
// Widths, request and status codes, basis matrices and fixed-point constants
// shared by the evaluator.
// ----------------------------------------------------------------------------
package cspe_pkg;

   // Coordinate and parameter formats
   localparam int COORD_WIDTH = 32;        // signed Q16.16
   localparam int U_FRAC_BITS = 16;        // u is Q1.16, unsigned
   localparam int U_WIDTH     = 17;        // room for 1.0

   // Stream word layout
   localparam int REQ_DATA_WIDTH = 120;    // x, y, z, u, zero fill
   localparam int RSP_DATA_WIDTH = 96;     // x, y, z
   localparam int CODE_WIDTH     = 2;
   localparam int X_LSB = 0;
   localparam int Y_LSB = COORD_WIDTH;
   localparam int Z_LSB = 2 * COORD_WIDTH;
   localparam int U_LSB = 3 * COORD_WIDTH;

   // Internal datapath widths
   localparam int P_WIDTH     = 19;        // powers, up to 3.0 in Q.16, signed
   localparam int N_WIDTH     = 24;        // basis row dot powers, signed
   localparam int W_WIDTH     = 22;        // weight, signed Q.16
   localparam int MUL_A_WIDTH = 33;
   localparam int MUL_B_WIDTH = 25;
   localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int ACC_WIDTH   = 57;        // four products plus rounding
   localparam int CNT_WIDTH   = 4;

   // Request codes (tuser of the request stream)
   localparam logic [CODE_WIDTH-1:0] REQ_PUSH = 2'd0;
   localparam logic [CODE_WIDTH-1:0] REQ_POS  = 2'd1;
   localparam logic [CODE_WIDTH-1:0] REQ_TAN  = 2'd2;

   // Status codes (tuser of the response stream)
   localparam logic [CODE_WIDTH-1:0] STATUS_OK      = 2'd0;
   localparam logic [CODE_WIDTH-1:0] STATUS_TOO_FEW = 2'd1;
   localparam logic [CODE_WIDTH-1:0] STATUS_SAT     = 2'd2;

   localparam logic [2:0] POINTS_FULL = 3'd4;

   // floor(y/6) = (y * RECIP_SIX) >> RECIP_SHIFT, exact for y below 2^25.
   // The bias makes y non-negative and folds in the +3 of round half up.
   localparam logic [N_WIDTH-1:0] RECIP_SIX  = 24'd11184811;
   localparam int                 RECIP_SHIFT = 26;
   localparam logic [N_WIDTH-1:0] DIV_BIAS   = 24'd12582915;   // 3 + 6*2^21
   localparam logic [W_WIDTH-1:0] W_BIAS     = 22'h200000;     // 2^21

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [3:0]             coef_type;

   localparam coef_type CR_BASIS [4][4] = '{
      '{ 4'sd0, -4'sd1,  4'sd2, -4'sd1 },
      '{ 4'sd2,  4'sd0, -4'sd5,  4'sd3 },
      '{ 4'sd0,  4'sd1,  4'sd4, -4'sd3 },
      '{ 4'sd0,  4'sd0, -4'sd1,  4'sd1 }
   };

   localparam coef_type BS_BASIS [4][4] = '{
      '{ 4'sd1, -4'sd3,  4'sd3, -4'sd1 },
      '{ 4'sd4,  4'sd0, -4'sd6,  4'sd3 },
      '{ 4'sd1,  4'sd3,  4'sd3, -4'sd3 },
      '{ 4'sd0,  4'sd0,  4'sd0,  4'sd1 }
   };

   function automatic coef_type basis_coef(input logic       bspline,
                                           input logic [1:0] row,
                                           input logic [1:0] col);
      coef_type c;
      if (bspline) begin
         c = BS_BASIS[row][col];
      end else begin
         c = CR_BASIS[row][col];
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/cubic_spline_point_evaluator.sv
// ----------------------------------------------------------------------------
// Cubic spline point evaluator
// Four-point sliding window of 3D control points; evaluates position or
// tangent of a uniform Catmull-Rom or B-spline segment with one shared
// multiplier under a small sequencer. Results saturate and flag overflow.
// ----------------------------------------------------------------------------
//
//   channel   dir   word                                    user
//   req_*     in    x[31:0] y[63:32] z[95:64] u[112:96]     request code
//   rsp_*     out   x[31:0] y[63:32] z[95:64]               status
//   csr_*     in    basis select, write only                -
//
// Push and unused codes are handled in the idle state. Evaluate/tangent
// runs from accept to result register through u^2 and u^3, the four
// weights (row sum, then scale through the multiplier), the twelve
// coordinate products, and the load of the result register.
// Too-few requests go straight to the result register.
// Sync active-high reset clears the point count, basis select and handshakes.
// A result waiting in the output register does not block pushes; the
// sequencer holds in its last step only while that register is full.

module cubic_spline_point_evaluator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic                                csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // point_x, point_y, point_z, param_u, zero fill
   input  logic [cspe_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // req_type
   input  logic [cspe_pkg::CODE_WIDTH-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_x, out_y, out_z
   output logic [cspe_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // status
   output logic [cspe_pkg::CODE_WIDTH-1:0]     rsp_tuser
);
   import cspe_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_U2    = 3'd1;
   localparam logic [2:0] ST_U3    = 3'd2;
   localparam logic [2:0] ST_WROW  = 3'd3;
   localparam logic [2:0] ST_WDIV  = 3'd4;
   localparam logic [2:0] ST_MAC   = 3'd5;
   localparam logic [2:0] ST_WRITE = 3'd6;

   localparam logic [U_WIDTH-1:0]   U_ONE     = U_WIDTH'(1) << U_FRAC_BITS;
   localparam logic [CNT_WIDTH-1:0] MAC_LAST  = 4'd12;
   localparam logic signed [ACC_WIDTH-1:0] ACC_HALF =
      ACC_WIDTH'(1) << (U_FRAC_BITS - 1);
   localparam logic signed [PROD_WIDTH-1:0] PROD_HALF =
      PROD_WIDTH'(1) << (U_FRAC_BITS - 1);
   localparam logic signed [ACC_WIDTH-1:0] ACC_CMAX =
      {{(ACC_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_CMIN =
      {{(ACC_WIDTH-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

   // ---- registers ----
   logic [2:0]                    state_ff, state_in;
   logic [CNT_WIDTH-1:0]          cnt_ff, cnt_in;
   logic                          basis_ff, basis_in;
   logic [2:0]                    loaded_ff, loaded_in;
   coord_type                     window_ff [4][3];
   coord_type                     window_in [4][3];
   logic                          tangent_ff, tangent_in;
   logic                          too_few_ff, too_few_in;
   logic                          sat_ff, sat_in;
   logic [U_WIDTH-1:0]            u_ff, u_in;
   logic [U_WIDTH-1:0]            u2_ff, u2_in;
   logic [U_WIDTH-1:0]            u3_ff, u3_in;
   logic signed [N_WIDTH-1:0]     n_ff, n_in;
   logic signed [W_WIDTH-1:0]     w_ff [4];
   logic signed [W_WIDTH-1:0]     w_in [4];
   logic signed [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic signed [ACC_WIDTH-1:0]   acc_ff, acc_in;
   coord_type                     res_ff [3];
   coord_type                     res_in [3];
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0]     rsp_data_ff, rsp_data_in;
   logic [CODE_WIDTH-1:0]         rsp_status_ff, rsp_status_in;

   // ---- combinational ----
   logic                          accept;
   logic                          out_free;
   logic [U_WIDTH-1:0]            req_u;
   logic signed [MUL_A_WIDTH-1:0] mul_a;
   logic signed [MUL_B_WIDTH-1:0] mul_b;
   logic signed [PROD_WIDTH-1:0]  mul_p;
   logic signed [PROD_WIDTH-1:0]  pow_rnd;
   logic signed [P_WIDTH-1:0]     pw [4];
   logic signed [N_WIDTH-1:0]     n_sum;
   logic [N_WIDTH-1:0]            div_y;
   logic signed [N_WIDTH-1:0]     n_inc;
   logic [1:0]                    row_sel;
   logic [1:0]                    axis_sel;
   coord_type                     coord_sel;
   logic [CNT_WIDTH-1:0]          mac_j;
   logic signed [ACC_WIDTH-1:0]   mac_sum;
   logic signed [ACC_WIDTH-1:0]   mac_shr;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_u      = req_tdata[U_LSB +: U_WIDTH];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // powers of u: position [1,u,u2,u3], tangent [0,1,2u,3u2]
   always_comb begin
      if (tangent_ff) begin
         pw[0] = '0;
         pw[1] = P_WIDTH'(U_ONE);
         pw[2] = P_WIDTH'({u_ff, 1'b0});
         pw[3] = P_WIDTH'(u2_ff) + P_WIDTH'({u2_ff, 1'b0});
      end else begin
         pw[0] = P_WIDTH'(U_ONE);
         pw[1] = P_WIDTH'(u_ff);
         pw[2] = P_WIDTH'(u2_ff);
         pw[3] = P_WIDTH'(u3_ff);
      end
   end

   assign row_sel = cnt_ff[1:0];

   // one basis row dotted with the powers; small constant coefficients
   always_comb begin
      n_sum = '0;
      for (int c = 0; c < 4; c++) begin
         n_sum = n_sum + N_WIDTH'(basis_coef(basis_ff, row_sel, 2'(c)))
                       * N_WIDTH'(pw[c]);
      end
   end

   assign div_y = N_WIDTH'(n_ff) + DIV_BIAS;
   assign n_inc = n_ff + N_WIDTH'(1);

   assign axis_sel  = (cnt_ff[3:2] == 2'd3) ? 2'd0 : cnt_ff[3:2];
   assign coord_sel = window_ff[row_sel][axis_sel];

   // shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_U2: begin
            mul_a = MUL_A_WIDTH'(u_ff);
            mul_b = MUL_B_WIDTH'(u_ff);
         end
         ST_U3: begin
            mul_a = MUL_A_WIDTH'(u2_ff);
            mul_b = MUL_B_WIDTH'(u_ff);
         end
         ST_WDIV: begin
            mul_a = MUL_A_WIDTH'(div_y);
            mul_b = MUL_B_WIDTH'(RECIP_SIX);
         end
         ST_MAC: begin
            mul_a = MUL_A_WIDTH'(coord_sel);
            mul_b = MUL_B_WIDTH'(w_ff[row_sel]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
   assign pow_rnd = mul_p + PROD_HALF;

   // accumulate the product registered in the previous step
   assign mac_j   = cnt_ff - CNT_WIDTH'(1);
   assign mac_sum = ((mac_j[1:0] == 2'd0) ? '0 : acc_ff) + ACC_WIDTH'(prod_ff);
   assign mac_shr = (mac_sum + ACC_HALF) >>> U_FRAC_BITS;

   // ---- sequencer and datapath next state ----
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      basis_in      = basis_ff;
      loaded_in     = loaded_ff;
      window_in     = window_ff;
      tangent_in    = tangent_ff;
      too_few_in    = too_few_ff;
      sat_in        = sat_ff;
      u_in          = u_ff;
      u2_in         = u2_ff;
      u3_in         = u3_ff;
      n_in          = n_ff;
      w_in          = w_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_we) begin
         basis_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == REQ_PUSH) begin
                  for (int r = 0; r < 3; r++) begin
                     window_in[r] = window_ff[r+1];
                  end
                  window_in[3][0] = req_tdata[X_LSB +: COORD_WIDTH];
                  window_in[3][1] = req_tdata[Y_LSB +: COORD_WIDTH];
                  window_in[3][2] = req_tdata[Z_LSB +: COORD_WIDTH];
                  if (loaded_ff != POINTS_FULL) begin
                     loaded_in = loaded_ff + 3'd1;
                  end
               end else if (req_tuser == REQ_POS || req_tuser == REQ_TAN) begin
                  tangent_in = (req_tuser == REQ_TAN);
                  sat_in     = 1'b0;
                  u_in       = (req_u > U_ONE) ? U_ONE : req_u;
                  cnt_in     = '0;
                  if (loaded_ff != POINTS_FULL) begin
                     too_few_in = 1'b1;
                     for (int a = 0; a < 3; a++) begin
                        res_in[a] = '0;
                     end
                     state_in = ST_WRITE;
                  end else begin
                     too_few_in = 1'b0;
                     state_in   = ST_U2;
                  end
               end
            end
         end
         ST_U2: begin
            u2_in    = pow_rnd[U_FRAC_BITS +: U_WIDTH];
            state_in = ST_U3;
         end
         ST_U3: begin
            u3_in    = pow_rnd[U_FRAC_BITS +: U_WIDTH];
            state_in = ST_WROW;
         end
         ST_WROW: begin
            n_in     = n_sum;
            state_in = ST_WDIV;
         end
         ST_WDIV: begin
            // round half up: B-spline floor((N+3)/6), Catmull-Rom floor((N+1)/2)
            if (basis_ff) begin
               w_in[row_sel] = mul_p[RECIP_SHIFT +: W_WIDTH] - W_BIAS;
            end else begin
               w_in[row_sel] = W_WIDTH'(n_inc >>> 1);
            end
            if (row_sel == 2'd3) begin
               cnt_in   = '0;
               state_in = ST_MAC;
            end else begin
               cnt_in   = cnt_ff + CNT_WIDTH'(1);
               state_in = ST_WROW;
            end
         end
         ST_MAC: begin
            prod_in = mul_p;
            if (cnt_ff != '0) begin
               acc_in = mac_sum;
               if (mac_j[1:0] == 2'd3) begin
                  if (mac_shr > ACC_CMAX) begin
                     res_in[mac_j[3:2]] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
                     sat_in = 1'b1;
                  end else if (mac_shr < ACC_CMIN) begin
                     res_in[mac_j[3:2]] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
                     sat_in = 1'b1;
                  end else begin
                     res_in[mac_j[3:2]] = COORD_WIDTH'(mac_shr);
                  end
               end
            end
            if (cnt_ff == MAC_LAST) begin
               state_in = ST_WRITE;
            end else begin
               cnt_in = cnt_ff + CNT_WIDTH'(1);
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_ff[2], res_ff[1], res_ff[0]};
               priority if (too_few_ff) begin
                  rsp_status_in = STATUS_TOO_FEW;
               end else if (sat_ff) begin
                  rsp_status_in = STATUS_SAT;
               end else begin
                  rsp_status_in = STATUS_OK;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         basis_ff     <= 1'b0;
         loaded_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         basis_ff     <= basis_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      window_ff     <= window_in;
      tangent_ff    <= tangent_in;
      too_few_ff    <= too_few_in;
      sat_ff        <= sat_in;
      u_ff          <= u_in;
      u2_ff         <= u2_in;
      u3_ff         <= u3_in;
      n_ff          <= n_in;
      w_ff          <= w_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   // ---- assertions ----
   a_loaded_max: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= POINTS_FULL)
      else $error("point count above four");

   a_loaded_hold: assert property (@(posedge clock) disable iff (reset)
      loaded_ff == POINTS_FULL |=> loaded_ff == POINTS_FULL)
      else $error("full point window lost its count");

   a_eval_start: assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser == REQ_POS || req_tuser == REQ_TAN)
         && loaded_ff == POINTS_FULL |=> state_ff == ST_U2)
      else $error("evaluation did not start on a full window");

   a_too_few_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_TOO_FEW |-> rsp_tdata == '0)
      else $error("too-few result carries nonzero data");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_SAT |->
         rsp_tdata[X_LSB+COORD_WIDTH-2 -: COORD_WIDTH-1]
            == {(COORD_WIDTH-1){~rsp_tdata[X_LSB+COORD_WIDTH-1]}}
         || rsp_tdata[Y_LSB+COORD_WIDTH-2 -: COORD_WIDTH-1]
            == {(COORD_WIDTH-1){~rsp_tdata[Y_LSB+COORD_WIDTH-1]}}
         || rsp_tdata[Z_LSB+COORD_WIDTH-2 -: COORD_WIDTH-1]
            == {(COORD_WIDTH-1){~rsp_tdata[Z_LSB+COORD_WIDTH-1]}})
      else $error("saturated status without a clamped coordinate");

endmodule

>>> dv/cubic_spline_point_evaluator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic spline point evaluator testbench
// Pushes control points and requests positions and tangents under both
// bases. A fixed-point spline model predicts each response word, and a
// scoreboard checks the words in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module cubic_spline_point_evaluator_tb;
   import cspe_pkg::*;

   localparam logic [CODE_WIDTH-1:0] REQ_UNUSED = 2'd3;
   localparam logic                  BASIS_CR   = 1'b0;
   localparam logic                  BASIS_BS   = 1'b1;
   localparam longint COORD_MAX = 64'sd2147483647;
   localparam longint COORD_MIN = -64'sd2147483648;
   localparam longint U_ONE     = 64'sd65536;
   localparam logic [U_WIDTH-1:0] U_FULL = 17'd65536;
   localparam logic [U_WIDTH-1:0] U_TOP  = 17'd131071;

   typedef struct {
      coord_type              px;
      coord_type              py;
      coord_type              pz;
      logic [CODE_WIDTH-1:0]  status;
   } spline_result_type;

   class spline_scoreboard;
      longint            ctrl_pts [12];
      int unsigned       n_loaded;
      logic              bspline_on;
      spline_result_type results_q [$];
      int                errors;

      function new();
         foreach (ctrl_pts[i]) ctrl_pts[i] = 0;
         n_loaded   = 0;
         bspline_on = BASIS_CR;
         errors     = 0;
      endfunction

      function int coef(logic bs, int r, int c);
         int row [4];
         if (bs) begin
            case (r)
               0: row = '{1, -3, 3, -1};
               1: row = '{4, 0, -6, 3};
               2: row = '{1, 3, 3, -3};
               default: row = '{0, 0, 0, 1};
            endcase
         end else begin
            case (r)
               0: row = '{0, -1, 2, -1};
               1: row = '{2, 0, -5, 3};
               2: row = '{0, 1, 4, -3};
               default: row = '{0, 0, -1, 1};
            endcase
         end
         return row[c];
      endfunction

      function longint floor_quot(longint a, longint b);
         longint q;
         q = a / b;
         if ((a % b) != 0 && a < 0) q--;
         return q;
      endfunction

      task report(string msg);
         if (errors < 50) $display("ERROR @%0t: %s", $realtime, msg);
         errors++;
      endtask

      // Update the window or queue the expected response for one accepted word.
      function void note_request(logic [CODE_WIDTH-1:0] kind, coord_type x, coord_type y,
                                 coord_type z, logic [U_WIDTH-1:0] u_in);
         spline_result_type exp_res;
         longint u, u2, u3, n, d, shi, slo, hi, lo, res;
         longint pw [4];
         longint w [4];
         longint sums [3];
         logic   clipped;
         if (kind == REQ_PUSH) begin
            for (int a = 0; a < 9; a++) ctrl_pts[a] = ctrl_pts[a + 3];
            ctrl_pts[9]  = longint'(x);
            ctrl_pts[10] = longint'(y);
            ctrl_pts[11] = longint'(z);
            if (n_loaded < 4) n_loaded++;
            return;
         end
         if (kind == REQ_UNUSED) return;
         if (n_loaded < 4) begin
            exp_res = '{px: '0, py: '0, pz: '0, status: STATUS_TOO_FEW};
            results_q.insert(results_q.size(), exp_res);
            return;
         end
         u = longint'(u_in);
         if (u > U_ONE) u = U_ONE;
         u2 = (u * u + U_ONE / 2) >>> 16;
         u3 = (u2 * u + U_ONE / 2) >>> 16;
         if (kind == REQ_POS) pw = '{U_ONE, u, u2, u3};
         else pw = '{0, U_ONE, 2 * u, 3 * u2};
         d = bspline_on ? 6 : 2;
         for (int r = 0; r < 4; r++) begin
            n = 0;
            for (int c = 0; c < 4; c++) n += coef(bspline_on, r, c) * pw[c];
            w[r] = floor_quot(2 * n + d, 2 * d);
         end
         clipped = 1'b0;
         for (int a = 0; a < 3; a++) begin
            shi = 0;
            slo = 0;
            for (int r = 0; r < 4; r++) begin
               hi = ctrl_pts[r * 3 + a] >>> 16;
               lo = ctrl_pts[r * 3 + a] - (hi <<< 16);
               shi += hi * w[r];
               slo += lo * w[r];
            end
            res = shi + ((slo + U_ONE / 2) >>> 16);
            if (res > COORD_MAX) begin
               res = COORD_MAX;
               clipped = 1'b1;
            end
            if (res < COORD_MIN) begin
               res = COORD_MIN;
               clipped = 1'b1;
            end
            sums[a] = res;
         end
         exp_res.px = coord_type'(sums[0]);
         exp_res.py = coord_type'(sums[1]);
         exp_res.pz = coord_type'(sums[2]);
         exp_res.status = clipped ? STATUS_SAT : STATUS_OK;
         results_q.insert(results_q.size(), exp_res);
      endfunction

      task check_result(logic [RSP_DATA_WIDTH-1:0] data,
                        logic [CODE_WIDTH-1:0] user);
         spline_result_type exp_res;
         coord_type gx, gy, gz;
         if (results_q.size() == 0) begin
            report($sformatf("unexpected response word %h / %0d", data, user));
            return;
         end
         exp_res = results_q.pop_front();
         gx = data[X_LSB +: COORD_WIDTH];
         gy = data[Y_LSB +: COORD_WIDTH];
         gz = data[Z_LSB +: COORD_WIDTH];
         if (gx !== exp_res.px) report($sformatf("x got %0d exp %0d", gx, exp_res.px));
         if (gy !== exp_res.py) report($sformatf("y got %0d exp %0d", gy, exp_res.py));
         if (gz !== exp_res.pz) report($sformatf("z got %0d exp %0d", gz, exp_res.pz));
         if (user !== exp_res.status)
            report($sformatf("status got %0d exp %0d", user, exp_res.status));
      endtask
   endclass

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      csr_we     = 1'b0;
   logic                      csr_wdata  = 1'b0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic [CODE_WIDTH-1:0]     req_tuser  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [CODE_WIDTH-1:0]     rsp_tuser;

   spline_scoreboard sb;
   bit               no_idle = 1'b0;
   int               sink_hold = 0;

   cubic_spline_point_evaluator i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return coord_type'($urandom);
         4, 5, 6:    return coord_type'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
         7:          return coord_type'(COORD_MAX);
         8:          return coord_type'(COORD_MIN);
         default:    return coord_type'($urandom_range(0, 32'h0001_ffff)) - 32'sh0001_0000;
      endcase
   endfunction

   function automatic logic [U_WIDTH-1:0] rand_u();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return U_FULL;
      if (r < 4) return U_WIDTH'($urandom_range(65537, 131071));
      return U_WIDTH'($urandom_range(0, 65536));
   endfunction

   // Sink side: rsp_tready drops for random stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (sink_hold != 0) begin
         rsp_tready <= 1'b0;
         sink_hold  <= sink_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!no_idle && $urandom_range(0, 5) == 0) sink_hold <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   task automatic send_req(logic [CODE_WIDTH-1:0] kind, coord_type x, coord_type y,
                           coord_type z, logic [U_WIDTH-1:0] u);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, u, z, y, x};
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, x, y, z, u);
   endtask

   // Drain outstanding responses, then let a push or dropped word settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.results_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_basis(logic v);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.bspline_on = v;
   endtask

   task automatic run_random(int target);
      int sent;
      int r;
      logic [CODE_WIDTH-1:0] kind;
      sent = 0;
      while (sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 40) kind = REQ_PUSH;
         else if (r < 68) kind = REQ_POS;
         else if (r < 96) kind = REQ_TAN;
         else kind = REQ_UNUSED;
         if (sent % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
         send_req(kind, rand_coord(), rand_coord(), rand_coord(), rand_u());
         if (kind != REQ_UNUSED) sent++;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Too few points loaded, Catmull-Rom basis
      write_basis(BASIS_CR);
      send_req(REQ_POS, 32'sd5, 32'sd6, 32'sd7, 17'd0);
      send_req(REQ_PUSH, coord_type'(COORD_MAX), coord_type'(COORD_MAX),
               coord_type'(COORD_MAX), U_TOP);
      send_req(REQ_TAN, '0, '0, '0, U_FULL);
      send_req(REQ_PUSH, coord_type'(COORD_MIN), coord_type'(COORD_MIN),
               coord_type'(COORD_MIN), 17'd0);
      send_req(REQ_PUSH, '0, '0, '0, 17'd1);
      send_req(REQ_POS, '1, '1, '1, 17'd32768);
      send_req(REQ_PUSH, coord_type'(COORD_MAX), coord_type'(COORD_MIN), 32'sd1, U_TOP);
      // Window full: ends of u, u above one, unused code, saturating tangents
      send_req(REQ_POS, '0, '0, '0, 17'd0);
      send_req(REQ_POS, '0, '0, '0, U_FULL);
      send_req(REQ_POS, '0, '0, '0, U_TOP);
      send_req(REQ_TAN, '0, '0, '0, 17'd0);
      send_req(REQ_TAN, '0, '0, '0, U_FULL);
      send_req(REQ_UNUSED, '1, '1, '1, U_TOP);
      send_req(REQ_POS, '0, '0, '0, 17'd12345);

      write_basis(BASIS_BS);
      send_req(REQ_PUSH, -32'sd1, 32'sd1, 32'sh0000_8000, 17'd0);
      send_req(REQ_POS, '0, '0, '0, 17'd0);
      send_req(REQ_TAN, '0, '0, '0, U_FULL);
      send_req(REQ_POS, '0, '0, '0, U_TOP);
      send_req(REQ_TAN, '0, '0, '0, 17'd40000);
      send_req(REQ_PUSH, coord_type'(COORD_MIN), coord_type'(COORD_MAX), '0, 17'd0);
      send_req(REQ_TAN, '0, '0, '0, 17'd65535);

      run_random(460);
      write_basis(BASIS_CR);
      run_random(460);
      write_basis(BASIS_BS);
      run_random(460);
      write_basis(BASIS_CR);
      run_random(460);

      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.results_q.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.results_q.size()));
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/cspe_pkg.sv
hw/rtl/cubic_spline_point_evaluator.sv
dv/cubic_spline_point_evaluator_tb.sv
